// ===== rtl/distance_to_rgb_gradient_defines.svh =====
// Assertion macros used by the top-level RTL file of the distance to RGB gradient block.
`ifndef DISTANCE_TO_RGB_GRADIENT_DEFINES_SVH
`define DISTANCE_TO_RGB_GRADIENT_DEFINES_SVH

// Same-cycle implication, checked on clk, off during rst.
`define DTRG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define DTRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dtrg_pkg.sv =====
// Types, constants and band color tables for the distance to RGB gradient block.
package dtrg_pkg;

  localparam int DistBits   = 12;
  localparam int LevelBits  = 8;
  localparam int BlinkBits  = 10;
  localparam int RegIdxBits = 3;
  localparam int BandBits   = 3;
  localparam int NumBits    = DistBits + LevelBits;

  // Configuration register indexes
  localparam logic [RegIdxBits-1:0] REG_FLOOR = 3'd0;
  localparam logic [RegIdxBits-1:0] REG_RED   = 3'd1;
  localparam logic [RegIdxBits-1:0] REG_AMBER = 3'd2;
  localparam logic [RegIdxBits-1:0] REG_GREEN = 3'd3;
  localparam logic [RegIdxBits-1:0] REG_TEAL  = 3'd4;
  localparam logic [RegIdxBits-1:0] REG_FAR   = 3'd5;

  // Color bands
  localparam logic [BandBits-1:0] BAND_NONE   = 3'd0;
  localparam logic [BandBits-1:0] BAND_RED    = 3'd1;
  localparam logic [BandBits-1:0] BAND_AMBER  = 3'd2;
  localparam logic [BandBits-1:0] BAND_YELLOW = 3'd3;
  localparam logic [BandBits-1:0] BAND_GREEN  = 3'd4;
  localparam logic [BandBits-1:0] BAND_TEAL   = 3'd5;
  localparam logic [BandBits-1:0] BAND_BLUE   = 3'd6;

  typedef struct packed {
    logic                switched_on;
    logic                has_distance;
    logic [DistBits-1:0] dist_cm;
  } in_item_t;

  typedef struct packed {
    logic                 led_write;
    logic [LevelBits-1:0] red_level;
    logic [LevelBits-1:0] green_level;
    logic [LevelBits-1:0] blue_level;
    logic [BlinkBits-1:0] blink_off_ms;
    logic                 showing;
    logic                 busy_res;
  } out_item_t;

  typedef struct packed {
    logic [DistBits-1:0] floor_cm;
    logic [DistBits-1:0] red_limit_cm;
    logic [DistBits-1:0] amber_limit_cm;
    logic [DistBits-1:0] green_limit_cm;
    logic [DistBits-1:0] teal_limit_cm;
    logic [DistBits-1:0] far_limit_cm;
  } cfg_t;

  // One channel ramp: start level, magnitude of the swing, and its direction.
  typedef struct packed {
    logic [LevelBits-1:0] y0;
    logic [LevelBits-1:0] dy;
    logic                 neg;
  } chan_t;

  typedef struct packed {
    chan_t                red;
    chan_t                green;
    chan_t                blue;
    logic [BlinkBits-1:0] blink;
  } band_lvl_t;

  function automatic band_lvl_t band_levels(input logic [BandBits-1:0] band);
    band_lvl_t l;
    l = '0;
    case (band)
      BAND_RED: begin
        l.red.y0 = 8'd255;
        l.blink  = 10'd25;
      end
      BAND_AMBER: begin
        l.red   = '{y0: 8'd255, dy: 8'd17,  neg: 1'b1};
        l.green = '{y0: 8'd0,   dy: 8'd238, neg: 1'b0};
        l.blink = 10'd100;
      end
      BAND_YELLOW: begin
        l.red   = '{y0: 8'd238, dy: 8'd238, neg: 1'b1};
        l.green = '{y0: 8'd238, dy: 8'd17,  neg: 1'b0};
        l.blink = 10'd250;
      end
      BAND_GREEN: begin
        l.red   = '{y0: 8'd0,   dy: 8'd26,  neg: 1'b0};
        l.green = '{y0: 8'd255, dy: 8'd165, neg: 1'b1};
        l.blue  = '{y0: 8'd0,   dy: 8'd82,  neg: 1'b0};
        l.blink = 10'd500;
      end
      BAND_TEAL: begin
        l.red   = '{y0: 8'd26, dy: 8'd26,  neg: 1'b1};
        l.green = '{y0: 8'd90, dy: 8'd90,  neg: 1'b1};
        l.blue  = '{y0: 8'd82, dy: 8'd173, neg: 1'b0};
        l.blink = 10'd1000;
      end
      BAND_BLUE: begin
        l.blue.y0 = 8'd255;
      end
      default: l = '0;
    endcase
    return l;
  endfunction

  // Quotient never exceeds the swing, so the level stays in 0..255.
  function automatic logic [LevelBits-1:0] apply_level(input chan_t c,
                                                       input logic [LevelBits-1:0] q);
    return c.neg ? (c.y0 - q) : (c.y0 + q);
  endfunction

endpackage

// ===== rtl/dtrg_band.sv =====
// Band selection: picks the color band of a distance and its interpolation end points.
module dtrg_band (
  input  logic [dtrg_pkg::DistBits-1:0] d,
  input  dtrg_pkg::cfg_t                cfg,
  output logic [dtrg_pkg::BandBits-1:0] band,
  output logic [dtrg_pkg::DistBits-1:0] lo,
  output logic [dtrg_pkg::DistBits-1:0] hi
);
  import dtrg_pkg::*;

  always_comb begin
    band = BAND_NONE;
    // Solid bands use a unit span so the divider sees a nonzero divisor.
    lo   = '0;
    hi   = DistBits'(1);
    if (d >= cfg.floor_cm && d <= cfg.red_limit_cm) begin
      band = BAND_RED;
    end else if (d > cfg.red_limit_cm && d <= cfg.amber_limit_cm) begin
      band = BAND_AMBER;
      lo   = cfg.red_limit_cm;
      hi   = cfg.amber_limit_cm;
    end else if (d > cfg.amber_limit_cm && d <= cfg.green_limit_cm) begin
      band = BAND_YELLOW;
      lo   = cfg.amber_limit_cm;
      hi   = cfg.green_limit_cm;
    end else if (d > cfg.green_limit_cm && d <= cfg.teal_limit_cm) begin
      band = BAND_GREEN;
      lo   = cfg.green_limit_cm;
      hi   = cfg.teal_limit_cm;
    end else if (d > cfg.teal_limit_cm && d <= cfg.far_limit_cm) begin
      band = BAND_TEAL;
      lo   = cfg.teal_limit_cm;
      hi   = cfg.far_limit_cm;
    end else if (d > cfg.far_limit_cm) begin
      band = BAND_BLUE;
    end
  end

endmodule

// ===== rtl/dtrg_div.sv =====
// Bit-serial restoring divider lane: one quotient bit per cycle.
module dtrg_div #(
  parameter int NumW = 20,
  parameter int QuoW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NumW-1:0]      num,
  input  logic [NumW-QuoW-1:0] den,
  output logic                 running,
  output logic [QuoW-1:0]      quo
);
  localparam int CntW = $clog2(QuoW + 1);

  logic [CntW-1:0] cnt;
  logic [NumW-1:0] rem;
  logic [NumW-1:0] dv;
  logic            fits;

  assign running = (cnt != '0);
  assign fits    = (rem >= dv);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CntW'(QuoW);
    end else if (running) begin
      cnt <= cnt - CntW'(1);
    end
  end

  // Divisor starts aligned to the top quotient bit and walks down one bit a cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dv  <= NumW'({den, {(QuoW-1){1'b0}}});
      quo <= '0;
    end else if (running) begin
      if (fits) begin
        rem <= rem - dv;
      end
      dv  <= dv >> 1;
      quo <= {quo[QuoW-2:0], fits};
    end
  end

endmodule

// ===== rtl/distance_to_rgb_gradient.sv =====
// Top level of the distance to RGB gradient display controller.
//
// Input channel in_valid/in_stall/in_data carries one controller step per
// transaction: the on/off level and, optionally, a fresh distance. Every
// step yields exactly one result transaction on out_valid/out_stall/out_data.
// Thresholds are written through cfg_wr_en/cfg_index/cfg_data; the user must
// write them only while idle, which the block does not enforce; indexes past
// the last register are ignored. A step that needs no color computation goes
// from acceptance to the done phase, which loads its result into the output
// register; the next step can be taken once that load is done. A color update
// runs through band selection, operand setup and divider start, the bit-serial
// divider lanes, which write the levels into the result register when all of
// them are done, and then the done phase, which loads the output register.
// in_stall is high from acceptance until the result reaches the output
// register; a stalled receiver holds the result there and blocks the next
// result, while one new step can still be accepted and worked on.
// Reset (rst, synchronous) returns the controller to waiting, off, no
// pending update, and the thresholds to 0, 25, 50, 150, 175, 200 cm.
`include "distance_to_rgb_gradient_defines.svh"
module distance_to_rgb_gradient (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [dtrg_pkg::RegIdxBits-1:0] cfg_index,
  input  logic [dtrg_pkg::DistBits-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dtrg_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dtrg_pkg::out_item_t             out_data
);
  import dtrg_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BAND = 3'd1;
  localparam logic [2:0] PH_LOAD = 3'd2;
  localparam logic [2:0] PH_DIV  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0]          phase;
  cfg_t                cfg;
  logic                ctrl_state;
  logic [DistBits-1:0] held_distance;
  logic                update_pending;
  logic                colour_done;
  out_item_t           res;
  logic [BandBits-1:0] band_q;
  logic [DistBits-1:0] lo_q;
  logic [DistBits-1:0] hi_q;

  logic                accept;
  logic                ctrl_next;
  logic                pending_next;
  logic                done_next;
  logic                step_grad;
  out_item_t           step_res;

  logic [BandBits-1:0] band_w;
  logic [DistBits-1:0] lo_w;
  logic [DistBits-1:0] hi_w;
  band_lvl_t           lvl;
  logic [DistBits-1:0] span_x;
  logic [DistBits-1:0] span_den;
  logic [NumBits-1:0]  num_r;
  logic [NumBits-1:0]  num_g;
  logic [NumBits-1:0]  num_b;
  logic                div_start;
  logic [2:0]          div_running;
  logic                div_busy;
  logic [LevelBits-1:0] quo_r;
  logic [LevelBits-1:0] quo_g;
  logic [LevelBits-1:0] quo_b;
  logic                out_load;

  assign in_stall = (phase != PH_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (phase == PH_DONE) && (!out_valid || !out_stall);

  // Controller rules, first match wins.
  always_comb begin
    ctrl_next    = ctrl_state;
    pending_next = update_pending | in_data.has_distance;
    done_next    = colour_done;
    step_grad    = 1'b0;
    step_res     = '0;
    if (!ctrl_state) begin
      if (in_data.switched_on) begin
        ctrl_next          = 1'b1;
        step_res.led_write = 1'b1;
      end
    end else if (pending_next) begin
      step_res.led_write = 1'b1;
      step_grad          = 1'b1;
      pending_next       = 1'b0;
      done_next          = 1'b1;
    end else if (!in_data.switched_on) begin
      ctrl_next          = 1'b0;
      step_res.led_write = 1'b1;
      done_next          = 1'b0;
    end
    step_res.showing  = ctrl_next;
    step_res.busy_res = in_data.switched_on & ~done_next;
  end

  dtrg_band u_band (
    .d    (held_distance),
    .cfg  (cfg),
    .band (band_w),
    .lo   (lo_w),
    .hi   (hi_w)
  );

  assign lvl       = band_levels(band_q);
  assign span_x    = held_distance - lo_q;
  assign span_den  = hi_q - lo_q;
  assign num_r     = NumBits'(lvl.red.dy) * NumBits'(span_x);
  assign num_g     = NumBits'(lvl.green.dy) * NumBits'(span_x);
  assign num_b     = NumBits'(lvl.blue.dy) * NumBits'(span_x);
  assign div_start = (phase == PH_LOAD);
  assign div_busy  = |div_running;

  dtrg_div #(.NumW(NumBits), .QuoW(LevelBits)) u_div_r (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num     (num_r),
    .den     (span_den),
    .running (div_running[0]),
    .quo     (quo_r)
  );

  dtrg_div #(.NumW(NumBits), .QuoW(LevelBits)) u_div_g (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num     (num_g),
    .den     (span_den),
    .running (div_running[1]),
    .quo     (quo_g)
  );

  dtrg_div #(.NumW(NumBits), .QuoW(LevelBits)) u_div_b (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num     (num_b),
    .den     (span_den),
    .running (div_running[2]),
    .quo     (quo_b)
  );

  // Configuration and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_cm       <= DistBits'(0);
      cfg.red_limit_cm   <= DistBits'(25);
      cfg.amber_limit_cm <= DistBits'(50);
      cfg.green_limit_cm <= DistBits'(150);
      cfg.teal_limit_cm  <= DistBits'(175);
      cfg.far_limit_cm   <= DistBits'(200);
      ctrl_state         <= 1'b0;
      held_distance      <= '0;
      update_pending     <= 1'b0;
      colour_done        <= 1'b0;
      phase              <= PH_IDLE;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FLOOR: cfg.floor_cm       <= cfg_data;
          REG_RED:   cfg.red_limit_cm   <= cfg_data;
          REG_AMBER: cfg.amber_limit_cm <= cfg_data;
          REG_GREEN: cfg.green_limit_cm <= cfg_data;
          REG_TEAL:  cfg.teal_limit_cm  <= cfg_data;
          REG_FAR:   cfg.far_limit_cm   <= cfg_data;
          default: ;
        endcase
      end
      case (phase)
        PH_IDLE: begin
          if (accept) begin
            ctrl_state     <= ctrl_next;
            update_pending <= pending_next;
            colour_done    <= done_next;
            if (in_data.has_distance) begin
              held_distance <= in_data.dist_cm;
            end
            phase <= step_grad ? PH_BAND : PH_DONE;
          end
        end
        PH_BAND: phase <= PH_LOAD;
        PH_LOAD: phase <= PH_DIV;
        PH_DIV: begin
          if (!div_busy) begin
            phase <= PH_DONE;
          end
        end
        PH_DONE: begin
          if (out_load) begin
            phase <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // Result assembly
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= step_res;
    end else if (phase == PH_DIV && !div_busy) begin
      res.red_level    <= apply_level(lvl.red, quo_r);
      res.green_level  <= apply_level(lvl.green, quo_g);
      res.blue_level   <= apply_level(lvl.blue, quo_b);
      res.blink_off_ms <= lvl.blink;
    end
    if (phase == PH_BAND) begin
      band_q <= band_w;
      lo_q   <= lo_w;
      hi_q   <= hi_w;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  `DTRG_ASSERT_NEXT(a_accept_dispatch, accept, (phase == PH_BAND) || (phase == PH_DONE), "accepted step did not dispatch")
  `DTRG_ASSERT_IMPL(a_busy_showing, out_valid && out_data.busy_res, out_data.showing, "busy reported while waiting")
  `DTRG_ASSERT_IMPL(a_color_written, out_valid && ((out_data.red_level != '0) || (out_data.green_level != '0) || (out_data.blue_level != '0) || (out_data.blink_off_ms != '0)), out_data.led_write, "color without LED write")
  `DTRG_ASSERT_IMPL(a_result_source, $rose(out_valid), $past(phase) == PH_DONE, "result appeared outside done phase")

endmodule
